// ===== hw/rtl/gwae_pkg.sv =====
// Shared types, constants and tables for the Gaussian world-box extents block.
// No dependencies; the other files in hw/rtl, except gwae_checker, refer to it by scoped names.
package gwae_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QueueDepthDef = 2;

  // Configuration register map (register index = byte address / 4).
  localparam logic       REG_SIGMA   = 1'b0;
  localparam logic [15:0] SIGMA_RESET = 16'd768;  // 3.0 in Q8.8

  // Arithmetic constants.
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;  // log2(e) in unsigned Q1.30
  localparam logic [31:0] Q30_ONE    = 32'd1073741824;
  localparam logic [29:0] POLY_TOP   = 30'd16378;       // highest Horner coefficient
  localparam logic signed [7:0] HALF_SHIFT = 8'sd22;
  localparam logic [63:0] ACC_ROUND  = 64'd536870912;   // 2^29
  localparam int unsigned DivSteps   = 16;              // two quotient bits per step

  localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
  localparam logic [31:0]        COUNT_MAX = 32'hFFFF_FFFF;

  // Coefficient added at each Horner step, highest power first; the last
  // step adds the leading one of the mantissa.
  function automatic logic [31:0] horner_coef(input logic [2:0] step);
    logic [31:0] c;
    case (step)
      3'd0:    c = 32'd165394;
      3'd1:    c = 32'd1431680;
      3'd2:    c = 32'd10327388;
      3'd3:    c = 32'd59597083;
      3'd4:    c = 32'd257941248;
      3'd5:    c = 32'd744261118;
      3'd6:    c = Q30_ONE;
      default: c = '0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_w;
    logic signed [15:0] log_scale_x;
    logic signed [15:0] log_scale_y;
    logic signed [15:0] log_scale_z;
    logic               first_of_set;
  } raw_t;

  typedef struct packed {
    raw_t raw;
    logic zero_quat;
  } item_t;

  typedef struct packed {
    logic [30:0]        half_extent_x;
    logic [30:0]        half_extent_y;
    logic [30:0]        half_extent_z;
    logic               is_invalid;
    logic signed [31:0] bound_min_x;
    logic signed [31:0] bound_min_y;
    logic signed [31:0] bound_min_z;
    logic signed [31:0] bound_max_x;
    logic signed [31:0] bound_max_y;
    logic signed [31:0] bound_max_z;
    logic [31:0]        invalid_total;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_NUM,
    ST_DIV,
    ST_MAC,
    ST_BOUND
  } state_e;

endpackage

// ===== hw/rtl/gwae_front.sv =====
// Front stage: accepts input items, flags a zero quaternion, and pushes
// the classified item toward the queue. Depends on gwae_pkg.
module gwae_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gwae_pkg::raw_t  raw_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output gwae_pkg::item_t push_item_o
);

  logic            valid_q;
  gwae_pkg::item_t item_q;
  logic            zero_quat;

  assign zero_quat  = (raw_i.quat_i == '0) && (raw_i.quat_j == '0) &&
                      (raw_i.quat_k == '0) && (raw_i.quat_w == '0);
  assign in_ready_o = !valid_q || push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{raw: raw_i, zero_quat: zero_quat};
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

// ===== hw/rtl/gwae_queue.sv =====
// Small FIFO of classified items between the front and back parts.
// Depends on gwae_pkg for the item type.
module gwae_queue #(
  parameter int unsigned Depth = gwae_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gwae_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gwae_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  gwae_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/gwae_back.sv =====
// Back part: sequenced datapath for one item at a time (rotation by lane
// dividers, exp2 by Horner lanes, matrix product, scene bounds). Uses gwae_pkg.
module gwae_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       sigma_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  gwae_pkg::item_t   pop_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gwae_pkg::result_t out_res_o
);

  localparam logic [3:0] StepLast  = 4'(gwae_pkg::DivSteps - 1);
  localparam logic [3:0] StepScale = 4'd7;
  localparam logic [3:0] StepShift = 4'd8;
  localparam logic [1:0] ColLast   = 2'd2;

  gwae_pkg::state_e  state_q, state_d;
  gwae_pkg::item_t   item_q;
  gwae_pkg::result_t res_q;

  logic [30:0]        sq_q   [4];
  logic signed [31:0] xp_q   [6];
  logic signed [47:0] ep_q   [3];
  logic [32:0]        n2_q;
  logic [32:0]        rem_q  [9];
  logic [31:0]        quo_q  [9];
  logic [3:0]         step_q;
  logic [1:0]         col_q;
  logic signed [7:0]  ip_q   [3];
  logic [29:0]        frac_q [3];
  logic [31:0]        hp_q   [3];
  logic [47:0]        scl_q  [3];
  logic [31:0]        half_q [3];
  logic [2:0]         big_q;
  logic [63:0]        acc_q  [3];
  logic signed [31:0] low_q  [3];
  logic signed [31:0] high_q [3];
  logic [31:0]        bad_cnt_q;
  logic               out_valid_q;
  logic               fire;

  // ---------------- operands
  logic signed [15:0] qv [4];
  logic signed [15:0] sv [3];
  logic signed [31:0] pv [3];
  assign qv[0] = item_q.raw.quat_i;
  assign qv[1] = item_q.raw.quat_j;
  assign qv[2] = item_q.raw.quat_k;
  assign qv[3] = item_q.raw.quat_w;
  assign sv[0] = item_q.raw.log_scale_x;
  assign sv[1] = item_q.raw.log_scale_y;
  assign sv[2] = item_q.raw.log_scale_z;
  assign pv[0] = item_q.raw.pos_x;
  assign pv[1] = item_q.raw.pos_y;
  assign pv[2] = item_q.raw.pos_z;

  // ---------------- products of the quaternion and the log scales
  logic signed [31:0] sq_full [4];
  logic signed [31:0] xp_full [6];
  logic signed [47:0] ep_full [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_full[i] = qv[i] * qv[i];
    end
    xp_full[0] = qv[0] * qv[1];
    xp_full[1] = qv[0] * qv[2];
    xp_full[2] = qv[1] * qv[2];
    xp_full[3] = qv[0] * qv[3];
    xp_full[4] = qv[1] * qv[3];
    xp_full[5] = qv[2] * qv[3];
    for (int a = 0; a < 3; a++) begin
      ep_full[a] = sv[a] * $signed({1'b0, gwae_pkg::LOG2E_Q30});
    end
  end

  // ---------------- rotation numerators and dividends
  function automatic logic [34:0] sx35(input logic [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  logic [32:0] n2;
  logic [34:0] n2w;
  logic [34:0] num [9];
  logic [32:0] mag [9];
  logic [62:0] dvd [9];

  always_comb begin
    n2  = {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]} + {2'b0, sq_q[3]};
    n2w = {2'b0, n2};
    num[0] = n2w - (({4'b0, sq_q[1]} + {4'b0, sq_q[2]}) << 1);
    num[1] = (sx35(xp_q[0]) - sx35(xp_q[5])) << 1;
    num[2] = (sx35(xp_q[1]) + sx35(xp_q[4])) << 1;
    num[3] = (sx35(xp_q[0]) + sx35(xp_q[5])) << 1;
    num[4] = n2w - (({4'b0, sq_q[0]} + {4'b0, sq_q[2]}) << 1);
    num[5] = (sx35(xp_q[2]) - sx35(xp_q[3])) << 1;
    num[6] = (sx35(xp_q[1]) - sx35(xp_q[4])) << 1;
    num[7] = (sx35(xp_q[2]) + sx35(xp_q[3])) << 1;
    num[8] = n2w - (({4'b0, sq_q[0]} + {4'b0, sq_q[1]}) << 1);
    for (int l = 0; l < 9; l++) begin
      mag[l] = num[l][34] ? 33'(~num[l] + 35'd1) : num[l][32:0];
      dvd[l] = {mag[l], 30'b0} + {31'b0, n2[32:1]};
    end
  end

  // ---------------- divider lanes, two quotient bits per cycle
  logic [32:0] rem_nx [9];
  logic [31:0] quo_nx [9];

  always_comb begin
    logic [33:0] dd, t1, t2, r1, r2;
    logic        ge1, ge2;
    dd = {1'b0, n2_q};
    for (int l = 0; l < 9; l++) begin
      t1  = {rem_q[l], quo_q[l][31]};
      ge1 = (t1 >= dd);
      r1  = ge1 ? t1 - dd : t1;
      t2  = {r1[32:0], quo_q[l][30]};
      ge2 = (t2 >= dd);
      r2  = ge2 ? t2 - dd : t2;
      rem_nx[l] = r2[32:0];
      quo_nx[l] = {quo_q[l][29:0], ge1, ge2};
    end
  end

  // ---------------- exp2 lanes: Horner step, scale, shift
  logic [31:0] hp_nx   [3];
  logic [47:0] scl_nx  [3];
  logic [31:0] half_nx [3];
  logic [2:0]  big_nx;

  always_comb begin
    logic [61:0]       hprod;
    logic signed [7:0] sh;
    logic [7:0]        rneg;
    logic [79:0]       wide;
    logic [47:0]       tr;
    logic [48:0]       rnd;
    for (int a = 0; a < 3; a++) begin
      hprod     = hp_q[a] * frac_q[a];
      hp_nx[a]  = gwae_pkg::horner_coef(step_q[2:0]) + hprod[61:30];
      scl_nx[a] = hp_q[a] * sigma_i;
      sh   = ip_q[a] - gwae_pkg::HALF_SHIFT;
      rneg = 8'(-sh);
      wide = {32'b0, scl_q[a]} << sh[4:0];
      tr   = scl_q[a] >> (rneg[6:0] - 7'd1);
      rnd  = ({1'b0, tr} + 49'd1) >> 1;
      if (scl_q[a] == '0) begin
        half_nx[a] = '0;
        big_nx[a]  = 1'b0;
      end else if (!sh[7]) begin
        half_nx[a] = wide[31:0];
        big_nx[a]  = (sh[6:5] != 2'b00) || (wide[79:32] != '0);
      end else if (rneg >= 8'd63) begin
        half_nx[a] = '0;
        big_nx[a]  = 1'b0;
      end else begin
        half_nx[a] = rnd[31:0];
        big_nx[a]  = (rnd[48:32] != '0);
      end
    end
  end

  // ---------------- matrix product, one column per cycle
  logic [63:0] acc_nx [3];

  always_comb begin
    logic [30:0] rsel;
    logic [62:0] mprod;
    for (int a = 0; a < 3; a++) begin
      if (item_q.zero_quat) begin
        rsel = (col_q == 2'(a)) ? gwae_pkg::Q30_ONE[30:0] : '0;
      end else begin
        rsel = quo_q[3*a][30:0];
      end
      mprod     = rsel * half_q[0];
      acc_nx[a] = acc_q[a] + {1'b0, mprod};
    end
  end

  // ---------------- extents and scene bounds
  logic [33:0]        ext  [3];
  logic               bad;
  logic signed [31:0] lo_nx [3];
  logic signed [31:0] hi_nx [3];
  logic [31:0]        cnt_nx;
  logic [30:0]        ext_out [3];

  function automatic logic signed [31:0] sat32(input logic [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? gwae_pkg::S32_MIN : gwae_pkg::S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    logic signed [31:0] base_lo, base_hi, lo, hi;
    logic [31:0]        base_cnt;
    bad = (big_q != '0);
    for (int a = 0; a < 3; a++) begin
      ext[a] = acc_q[a][63:30];
      if (ext[a][33:31] != '0) begin
        bad = 1'b1;
      end
    end
    for (int a = 0; a < 3; a++) begin
      base_lo = item_q.raw.first_of_set ? gwae_pkg::S32_MAX : low_q[a];
      base_hi = item_q.raw.first_of_set ? gwae_pkg::S32_MIN : high_q[a];
      lo = sat32({pv[a][31], pv[a]} - {2'b0, ext[a][30:0]});
      hi = sat32({pv[a][31], pv[a]} + {2'b0, ext[a][30:0]});
      if (bad) begin
        lo_nx[a]   = base_lo;
        hi_nx[a]   = base_hi;
        ext_out[a] = '0;
      end else begin
        lo_nx[a]   = (lo < base_lo) ? lo : base_lo;
        hi_nx[a]   = (hi > base_hi) ? hi : base_hi;
        ext_out[a] = ext[a][30:0];
      end
    end
    base_cnt = item_q.raw.first_of_set ? '0 : bad_cnt_q;
    cnt_nx   = (bad && base_cnt != gwae_pkg::COUNT_MAX) ? base_cnt + 32'd1 : base_cnt;
  end

  // ---------------- sequencer
  assign fire        = (state_q == gwae_pkg::ST_BOUND) && (!out_valid_q || out_ready_i);
  assign pop_ready_o = (state_q == gwae_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      gwae_pkg::ST_IDLE:  if (pop_valid_i) state_d = gwae_pkg::ST_PROD;
      gwae_pkg::ST_PROD:  state_d = gwae_pkg::ST_NUM;
      gwae_pkg::ST_NUM:   state_d = gwae_pkg::ST_DIV;
      gwae_pkg::ST_DIV:   if (step_q == StepLast) state_d = gwae_pkg::ST_MAC;
      gwae_pkg::ST_MAC:   if (col_q == ColLast) state_d = gwae_pkg::ST_BOUND;
      gwae_pkg::ST_BOUND: if (fire) state_d = gwae_pkg::ST_IDLE;
      default:            state_d = gwae_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gwae_pkg::ST_IDLE;
      step_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      bad_cnt_q   <= '0;
      for (int a = 0; a < 3; a++) begin
        low_q[a]  <= gwae_pkg::S32_MAX;
        high_q[a] <= gwae_pkg::S32_MIN;
      end
    end else begin
      state_q <= state_d;
      if (state_q == gwae_pkg::ST_NUM) begin
        step_q <= '0;
      end else if (state_q == gwae_pkg::ST_DIV) begin
        step_q <= step_q + 4'd1;
      end
      if (state_q == gwae_pkg::ST_DIV) begin
        col_q <= '0;
      end else if (state_q == gwae_pkg::ST_MAC) begin
        col_q <= col_q + 2'd1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        bad_cnt_q   <= cnt_nx;
        for (int a = 0; a < 3; a++) begin
          low_q[a]  <= lo_nx[a];
          high_q[a] <= hi_nx[a];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gwae_pkg::ST_IDLE: begin
        if (pop_valid_i) item_q <= pop_item_i;
      end
      gwae_pkg::ST_PROD: begin
        for (int i = 0; i < 4; i++) sq_q[i] <= sq_full[i][30:0];
        for (int i = 0; i < 6; i++) xp_q[i] <= xp_full[i];
        for (int a = 0; a < 3; a++) ep_q[a] <= ep_full[a];
      end
      gwae_pkg::ST_NUM: begin
        n2_q <= n2;
        for (int l = 0; l < 9; l++) begin
          rem_q[l] <= {2'b0, dvd[l][62:32]};
          quo_q[l] <= dvd[l][31:0];
        end
        for (int a = 0; a < 3; a++) begin
          ip_q[a]   <= ep_q[a][47:40];
          frac_q[a] <= ep_q[a][39:10];
          hp_q[a]   <= {2'b0, gwae_pkg::POLY_TOP};
        end
      end
      gwae_pkg::ST_DIV: begin
        for (int l = 0; l < 9; l++) begin
          rem_q[l] <= rem_nx[l];
          quo_q[l] <= quo_nx[l];
        end
        for (int a = 0; a < 3; a++) begin
          if (step_q < StepScale) hp_q[a] <= hp_nx[a];
          if (step_q == StepScale) scl_q[a] <= scl_nx[a];
          if (step_q == StepShift) half_q[a] <= half_nx[a];
          if (step_q == StepLast) acc_q[a] <= gwae_pkg::ACC_ROUND;
        end
        if (step_q == StepShift) big_q <= big_nx;
      end
      gwae_pkg::ST_MAC: begin
        // advance one column: shift each row and the half vector left
        for (int a = 0; a < 3; a++) begin
          acc_q[a]       <= acc_nx[a];
          quo_q[3*a]     <= quo_q[3*a+1];
          quo_q[3*a+1]   <= quo_q[3*a+2];
        end
        half_q[0] <= half_q[1];
        half_q[1] <= half_q[2];
      end
      gwae_pkg::ST_BOUND: begin
        if (fire) begin
          res_q.half_extent_x <= ext_out[0];
          res_q.half_extent_y <= ext_out[1];
          res_q.half_extent_z <= ext_out[2];
          res_q.is_invalid    <= bad;
          res_q.bound_min_x   <= lo_nx[0];
          res_q.bound_min_y   <= lo_nx[1];
          res_q.bound_min_z   <= lo_nx[2];
          res_q.bound_max_x   <= hi_nx[0];
          res_q.bound_max_y   <= hi_nx[1];
          res_q.bound_max_z   <= hi_nx[2];
          res_q.invalid_total <= cnt_nx;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== hw/rtl/gaussian_world_aabb_extents.sv =====
// Gaussian world-axis box extents: one Gaussian in, one result out. Each item
// passes through the back datapath in order: taking it from the queue, a
// product step, a numerator step, a divide phase in which the nine lane
// dividers form the normalized rotation magnitudes two quotient bits per
// cycle, a matrix-product step for each column and a bound step; the exp2 Horner lanes
// run alongside the dividers. The bound step stretches while the previous
// result still waits in the output register. A front register and a small
// queue (QueueDepth items) take new items while the back works. Results come
// out in order. sigma_multiplier (Q8.8) sits at byte address 0 of the
// APB-style port and must only be written while the block is idle. Depends on
// gwae_pkg, gwae_front, gwae_queue and gwae_back.
module gaussian_world_aabb_extents #(
  parameter int unsigned QueueDepth = gwae_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_i_i,
  input  logic signed [15:0] quat_j_i,
  input  logic signed [15:0] quat_k_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] log_scale_x_i,
  input  logic signed [15:0] log_scale_y_i,
  input  logic signed [15:0] log_scale_z_i,
  input  logic               first_of_set_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        half_extent_x_o,
  output logic [30:0]        half_extent_y_o,
  output logic [30:0]        half_extent_z_o,
  output logic               is_invalid_o,
  output logic signed [31:0] bound_min_x_o,
  output logic signed [31:0] bound_min_y_o,
  output logic signed [31:0] bound_min_z_o,
  output logic signed [31:0] bound_max_x_o,
  output logic signed [31:0] bound_max_y_o,
  output logic signed [31:0] bound_max_z_o,
  output logic [31:0]        invalid_total_o
);

  // Configuration register: written in the APB access phase.
  logic [15:0] sigma_q;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == gwae_pkg::REG_SIGMA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= gwae_pkg::SIGMA_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sigma_q <= pwdata[15:0];
    end
  end

  assign prdata = reg_hit ? {16'b0, sigma_q} : '0;

  // Gather the input fields into one item.
  gwae_pkg::raw_t    raw;
  gwae_pkg::item_t   push_item, pop_item;
  gwae_pkg::result_t res;
  logic              push_valid, push_ready, pop_valid, pop_ready;

  assign raw = '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                 quat_i: quat_i_i, quat_j: quat_j_i, quat_k: quat_k_i,
                 quat_w: quat_w_i, log_scale_x: log_scale_x_i,
                 log_scale_y: log_scale_y_i, log_scale_z: log_scale_z_i,
                 first_of_set: first_of_set_i};

  // Front: accept and classify.
  gwae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_i        (raw),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Queue: decouple the front from the sequenced back.
  gwae_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: compute extents and update the scene bounds.
  gwae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sigma_i     (sigma_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign half_extent_x_o = res.half_extent_x;
  assign half_extent_y_o = res.half_extent_y;
  assign half_extent_z_o = res.half_extent_z;
  assign is_invalid_o    = res.is_invalid;
  assign bound_min_x_o   = res.bound_min_x;
  assign bound_min_y_o   = res.bound_min_y;
  assign bound_min_z_o   = res.bound_min_z;
  assign bound_max_x_o   = res.bound_max_x;
  assign bound_max_y_o   = res.bound_max_y;
  assign bound_max_z_o   = res.bound_max_z;
  assign invalid_total_o = res.invalid_total;

endmodule

// ===== hw/rtl/gwae_checker.sv =====
// Port-level checks for gaussian_world_aabb_extents, bound to the top level.
// Depends only on the top level's ports.
module gwae_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [30:0]        half_extent_x_o,
  input logic [30:0]        half_extent_y_o,
  input logic [30:0]        half_extent_z_o,
  input logic               is_invalid_o,
  input logic signed [31:0] bound_min_x_o,
  input logic signed [31:0] bound_min_y_o,
  input logic signed [31:0] bound_min_z_o,
  input logic signed [31:0] bound_max_x_o,
  input logic signed [31:0] bound_max_y_o,
  input logic signed [31:0] bound_max_z_o,
  input logic [31:0]        invalid_total_o
);

  // hold a stalled result (valid and four of its fields)
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(half_extent_x_o) &&
      $stable(bound_min_x_o) && $stable(bound_max_z_o) && $stable(invalid_total_o))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_invalid_o |->
      half_extent_x_o == '0 && half_extent_y_o == '0 && half_extent_z_o == '0)
    else $error("invalid item carries nonzero extents");

  a_bad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_invalid_o |-> invalid_total_o != '0)
    else $error("invalid item not counted");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_invalid_o |->
      bound_min_x_o <= bound_max_x_o && bound_min_y_o <= bound_max_y_o &&
      bound_min_z_o <= bound_max_z_o)
    else $error("scene bounds inverted after a valid item");

endmodule

bind gaussian_world_aabb_extents gwae_checker u_gwae_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .half_extent_x_o (half_extent_x_o),
  .half_extent_y_o (half_extent_y_o),
  .half_extent_z_o (half_extent_z_o),
  .is_invalid_o    (is_invalid_o),
  .bound_min_x_o   (bound_min_x_o),
  .bound_min_y_o   (bound_min_y_o),
  .bound_min_z_o   (bound_min_z_o),
  .bound_max_x_o   (bound_max_x_o),
  .bound_max_y_o   (bound_max_y_o),
  .bound_max_z_o   (bound_max_z_o),
  .invalid_total_o (invalid_total_o)
);

// ===== test/gwae_aabb_checker.sv =====
// Checker for the Gaussian world-box extents block: watches the config port and
// both item channels, predicts every result and compares it. Depends on gwae_pkg.
module gwae_aabb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  gwae_pkg::raw_t     gauss_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  gwae_pkg::result_t  extent_i,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HALF_CAP = 64'd4294967296;
  localparam longint unsigned EXP2_COEF [7] = '{
    64'd744261118, 64'd257941248, 64'd59597083, 64'd10327388,
    64'd1431680, 64'd165394, 64'd16378
  };

  logic [15:0]       sigma_q88;
  logic signed [31:0] scene_lo [3];
  logic signed [31:0] scene_hi [3];
  logic [31:0]       invalid_cnt;
  gwae_pkg::result_t expected_extents [$];

  assign pending_o = expected_extents.size();

  // 2^f for f in Q0.30, result Q1.30
  function automatic longint unsigned exp2_frac(longint unsigned f);
    longint unsigned p;
    p = EXP2_COEF[6];
    for (int k = 5; k >= 0; k--) p = EXP2_COEF[k] + ((p * f) >> 30);
    return ONE_Q30 + ((p * f) >> 30);
  endfunction

  // local half size in Q.16; returns 1 when it does not fit in 32 bits
  function automatic bit half_size(logic signed [15:0] s, output longint unsigned h);
    longint y;
    longint unsigned u, f, prod, v;
    int ip, sh;
    y = longint'(s) * 64'sd1549082005 + (64'sd47 <<< 40);
    u = y;
    ip = int'(u >> 40) - 47;
    f = (u >> 10) & (ONE_Q30 - 1);
    prod = exp2_frac(f) * longint'(sigma_q88);
    sh = ip - 22;
    h = 0;
    if (prod == 0) return 0;
    if (sh >= 0) begin
      if (sh >= 32 || prod > ((HALF_CAP - 1) >> sh)) return 1;
      v = prod << sh;
    end else if (-sh >= 63) begin
      v = 0;
    end else begin
      v = (prod + (64'd1 << (-sh - 1))) >> (-sh);
    end
    if (v >= HALF_CAP) return 1;
    h = v;
    return 0;
  endfunction

  // |num| / n2 in unsigned Q1.30, rounded half up
  function automatic longint unsigned rot_mag(longint num, longint n2);
    longint unsigned a;
    a = (num < 0) ? -num : num;
    return ((a << 30) + longint'(n2) / 2) / n2;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return gwae_pkg::S32_MAX;
    if (v < -64'sd2147483648) return gwae_pkg::S32_MIN;
    return v[31:0];
  endfunction

  function automatic gwae_pkg::result_t predict_extents(gwae_pkg::raw_t g);
    gwae_pkg::result_t r;
    longint qi, qj, qk, qw, n2;
    longint pos [3];
    longint unsigned rm [3][3];
    longint unsigned hh [3];
    longint unsigned ext [3];
    longint unsigned acc;
    bit bad;
    pos[0] = g.pos_x; pos[1] = g.pos_y; pos[2] = g.pos_z;
    qi = g.quat_i; qj = g.quat_j; qk = g.quat_k; qw = g.quat_w;
    bad = 0;
    if (g.first_of_set) begin
      for (int a = 0; a < 3; a++) begin
        scene_lo[a] = gwae_pkg::S32_MAX;
        scene_hi[a] = gwae_pkg::S32_MIN;
      end
      invalid_cnt = '0;
    end
    n2 = qi*qi + qj*qj + qk*qk + qw*qw;
    if (n2 == 0) begin
      // zero quaternion stays unnormalized: identity rotation
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) rm[a][b] = (a == b) ? ONE_Q30 : 0;
    end else begin
      rm[0][0] = rot_mag(n2 - 2*(qj*qj + qk*qk), n2);
      rm[0][1] = rot_mag(2*(qi*qj - qk*qw), n2);
      rm[0][2] = rot_mag(2*(qi*qk + qj*qw), n2);
      rm[1][0] = rot_mag(2*(qi*qj + qk*qw), n2);
      rm[1][1] = rot_mag(n2 - 2*(qi*qi + qk*qk), n2);
      rm[1][2] = rot_mag(2*(qj*qk - qi*qw), n2);
      rm[2][0] = rot_mag(2*(qi*qk - qj*qw), n2);
      rm[2][1] = rot_mag(2*(qj*qk + qi*qw), n2);
      rm[2][2] = rot_mag(n2 - 2*(qi*qi + qj*qj), n2);
    end
    if (half_size(g.log_scale_x, hh[0])) bad = 1;
    if (half_size(g.log_scale_y, hh[1])) bad = 1;
    if (half_size(g.log_scale_z, hh[2])) bad = 1;
    for (int a = 0; a < 3; a++) ext[a] = 0;
    if (!bad) begin
      for (int a = 0; a < 3; a++) begin
        acc = 64'd1 << 29;
        for (int b = 0; b < 3; b++) acc += rm[a][b] * hh[b];
        ext[a] = acc >> 30;
        if (ext[a] > 64'h7FFF_FFFF) bad = 1;
      end
    end
    if (bad) begin
      for (int a = 0; a < 3; a++) ext[a] = 0;
      if (invalid_cnt != gwae_pkg::COUNT_MAX) invalid_cnt++;
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (clamp32(pos[a] - longint'(ext[a])) < scene_lo[a])
          scene_lo[a] = clamp32(pos[a] - longint'(ext[a]));
        if (clamp32(pos[a] + longint'(ext[a])) > scene_hi[a])
          scene_hi[a] = clamp32(pos[a] + longint'(ext[a]));
      end
    end
    r.half_extent_x = ext[0][30:0];
    r.half_extent_y = ext[1][30:0];
    r.half_extent_z = ext[2][30:0];
    r.is_invalid    = bad;
    r.bound_min_x   = scene_lo[0];
    r.bound_min_y   = scene_lo[1];
    r.bound_min_z   = scene_lo[2];
    r.bound_max_x   = scene_hi[0];
    r.bound_max_y   = scene_hi[1];
    r.bound_max_z   = scene_hi[2];
    r.invalid_total = invalid_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gwae_pkg::result_t e;
    if (!rst_ni) begin
      sigma_q88   = gwae_pkg::SIGMA_RESET;
      invalid_cnt = '0;
      for (int a = 0; a < 3; a++) begin
        scene_lo[a] = gwae_pkg::S32_MAX;
        scene_hi[a] = gwae_pkg::S32_MIN;
      end
      expected_extents.delete();
      err_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == gwae_pkg::REG_SIGMA)
        sigma_q88 = pwdata[15:0];
      if (in_valid_i && in_ready_i) expected_extents.push_back(predict_extents(gauss_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_extents.size() == 0) begin
          $error("result item with no expectation waiting");
          err_count_o++;
        end else begin
          e = expected_extents.pop_front();
          check_field("half_extent_x", e.half_extent_x, extent_i.half_extent_x);
          check_field("half_extent_y", e.half_extent_y, extent_i.half_extent_y);
          check_field("half_extent_z", e.half_extent_z, extent_i.half_extent_z);
          check_field("is_invalid", e.is_invalid, extent_i.is_invalid);
          check_field("bound_min_x", e.bound_min_x, extent_i.bound_min_x);
          check_field("bound_min_y", e.bound_min_y, extent_i.bound_min_y);
          check_field("bound_min_z", e.bound_min_z, extent_i.bound_min_z);
          check_field("bound_max_x", e.bound_max_x, extent_i.bound_max_x);
          check_field("bound_max_y", e.bound_max_y, extent_i.bound_max_y);
          check_field("bound_max_z", e.bound_max_z, extent_i.bound_max_z);
          check_field("invalid_total", e.invalid_total, extent_i.invalid_total);
        end
      end
    end
  end

endmodule

// ===== test/tb_gaussian_world_aabb_extents.sv =====
// Top of the Gaussian world-box extents testbench: clock, reset, config writes,
// item stimulus, output stalls and verdict. Depends on gwae_pkg and gwae_aabb_checker.
module tb_gaussian_world_aabb_extents;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;  // cycles without any handshake before giving up

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  gwae_pkg::raw_t gauss = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  gwae_pkg::result_t extent;
  int err_count, pending;
  int items_sent = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  gaussian_world_aabb_extents uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .pos_x_i(gauss.pos_x), .pos_y_i(gauss.pos_y), .pos_z_i(gauss.pos_z),
    .quat_i_i(gauss.quat_i), .quat_j_i(gauss.quat_j), .quat_k_i(gauss.quat_k),
    .quat_w_i(gauss.quat_w), .log_scale_x_i(gauss.log_scale_x),
    .log_scale_y_i(gauss.log_scale_y), .log_scale_z_i(gauss.log_scale_z),
    .first_of_set_i(gauss.first_of_set),
    .out_valid_o, .out_ready_i,
    .half_extent_x_o(extent.half_extent_x), .half_extent_y_o(extent.half_extent_y),
    .half_extent_z_o(extent.half_extent_z), .is_invalid_o(extent.is_invalid),
    .bound_min_x_o(extent.bound_min_x), .bound_min_y_o(extent.bound_min_y),
    .bound_min_z_o(extent.bound_min_z), .bound_max_x_o(extent.bound_max_x),
    .bound_max_y_o(extent.bound_max_y), .bound_max_z_o(extent.bound_max_z),
    .invalid_total_o(extent.invalid_total)
  );

  gwae_aabb_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .gauss_i(gauss),
    .out_valid_i(out_valid_o), .out_ready_i, .extent_i(extent),
    .err_count_o(err_count), .pending_o(pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Drop the offer, drain the block, then give the back datapath time to go quiet.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; register takes it at the end of the access cycle.
  task automatic write_sigma(logic [15:0] val);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {gwae_pkg::REG_SIGMA, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item, hold it until accepted, then idle for a random gap.
  task automatic send_gauss(gwae_pkg::raw_t g);
    int gap;
    gauss      <= g;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Most items are plausible Gaussians (log sigma roughly -9..3); the rest are
  // fully random noise that reaches the overflow and flush-to-zero corners.
  function automatic gwae_pkg::raw_t rand_gauss();
    gwae_pkg::raw_t g;
    g.pos_x = $urandom; g.pos_y = $urandom; g.pos_z = $urandom;
    g.quat_i = 16'($urandom); g.quat_j = 16'($urandom);
    g.quat_k = 16'($urandom); g.quat_w = 16'($urandom);
    g.log_scale_x = 16'($urandom); g.log_scale_y = 16'($urandom);
    g.log_scale_z = 16'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      g.log_scale_x = 16'($signed($urandom_range(0, 12000)) - 9000);
      g.log_scale_y = 16'($signed($urandom_range(0, 12000)) - 9000);
      g.log_scale_z = 16'($signed($urandom_range(0, 12000)) - 9000);
      if ($urandom_range(0, 3) == 0) g.pos_x = $signed($urandom_range(0, 2000000)) - 1000000;
    end
    g.first_of_set = ($urandom_range(0, 39) == 0);
    return g;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_gauss(rand_gauss());
  endtask

  task automatic send_directed();
    gwae_pkg::raw_t g;
    // plain unit quaternion, zero log scales, start of a set
    g = '0; g.quat_w = 16'sd16384; g.first_of_set = 1'b1;
    send_gauss(g);
    // zero quaternion: identity rotation
    g = '0; g.log_scale_x = 16'sd1024; g.log_scale_y = -16'sd1024;
    send_gauss(g);
    // extreme positions saturate the bounds
    g = '0; g.quat_w = 16'sd16384; g.pos_x = 32'sh7FFF_FFFF; g.pos_y = 32'sh8000_0000;
    g.pos_z = 32'sh7FFF_FFFF; g.log_scale_x = 16'sd5000;
    g.log_scale_y = 16'sd5000; g.log_scale_z = 16'sd5000;
    send_gauss(g);
    g.pos_x = 32'sh8000_0000; g.pos_y = 32'sh7FFF_FFFF; g.pos_z = 32'sh8000_0000;
    send_gauss(g);
    // largest log scale: huge local half, invalid
    g = '0; g.quat_w = 16'sd16384; g.log_scale_x = 16'sh7FFF;
    send_gauss(g);
    g.log_scale_x = '0; g.log_scale_z = 16'sh7FFF;
    send_gauss(g);
    // smallest log scales: halves flush to zero
    g = '0; g.quat_i = 16'sh7FFF; g.log_scale_x = 16'sh8000;
    g.log_scale_y = 16'sh8000; g.log_scale_z = 16'sh8000;
    send_gauss(g);
    // extreme quaternion components, all signs
    g = '0; g.quat_i = 16'sh8000; g.quat_j = 16'sh8000; g.quat_k = 16'sh8000;
    g.quat_w = 16'sh8000; g.log_scale_y = 16'sd3000;
    send_gauss(g);
    g.quat_i = 16'sh7FFF; g.quat_j = 16'sh8000; g.quat_k = 16'sh7FFF; g.quat_w = 16'sh0001;
    send_gauss(g);
    // local halves just past the 32-bit range at the reset multiplier, rotated
    g = '0; g.quat_i = 16'sd11585; g.quat_w = 16'sd11585;
    g.log_scale_x = 16'sd10300; g.log_scale_y = 16'sd10300; g.log_scale_z = 16'sd10300;
    send_gauss(g);
    // new set after invalid items clears count and bounds
    g = '0; g.quat_k = 16'sd16384; g.pos_x = -32'sd65536; g.log_scale_x = -16'sd2048;
    g.first_of_set = 1'b1;
    send_gauss(g);
    g.first_of_set = 1'b0; g.pos_x = 32'sd65536; g.pos_y = 32'sd12345;
    send_gauss(g);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    bit held;
    held = 0;
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!held && items_sent >= 40) begin
        held = 1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (pick_gap() > 0) begin
        out_ready_i <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog: any handshake or config access resets the idle count.
  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_sigma(16'd768);
    send_directed();
    send_random(150);
    write_sigma(16'd0);       // zero multiplier: all extents zero, items valid
    send_directed();
    send_random(50);
    write_sigma(16'hFFFF);    // largest multiplier: many overflows
    send_directed();
    send_random(120);
    write_sigma(16'd1);
    send_random(60);
    write_sigma(16'($urandom));
    send_random(60);
    write_sigma(16'd256);
    send_random(160);
    in_valid_i <= 1'b0;
    wait_idle();
    if (err_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
